### rtl/hem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hem_pkg
// shared types and constants of the hdr exposure merge unit
// ----------------------------------------------------------------------------
package hem_pkg;

  localparam int LEVEL_BITS_DEF = 16;
  localparam int SAMPLE_W       = 16;
  localparam int RESP_W         = 24;
  localparam int WEIGHT_W       = 16;
  localparam int SCALE_W        = 24;
  localparam int ACC_W          = 64;
  localparam int FRAC_BITS      = 16;
  localparam int RAD_W          = 24;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic       REQ_SAMPLE = 1'b0;
  localparam logic       REQ_LOAD   = 1'b1;
  localparam logic [1:0] SEL_RED    = 2'd0;
  localparam logic [1:0] SEL_GREEN  = 2'd1;
  localparam logic [1:0] SEL_BLUE   = 2'd2;
  localparam logic [1:0] SEL_WEIGHT = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [15:0] red_sample;
    logic [15:0] green_sample;
    logic [15:0] blue_sample;
    logic [23:0] exposure_scale;
    logic        last_exposure;
    logic [1:0]  table_select;
    logic [15:0] table_index;
    logic [23:0] table_value;
  } hem_in_t;

  typedef struct packed {
    logic [23:0] red_radiance;
    logic [23:0] green_radiance;
    logic [23:0] blue_radiance;
  } hem_out_t;

  // back-end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } hem_state_t;

endpackage

### rtl/hem_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hem_front
// accepts items, writes table loads into the curve memories, queues samples
// ----------------------------------------------------------------------------
module hem_front import hem_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hem_in_t               in_data,
  // sample queue toward the back end
  output logic                  q_valid,
  input  logic                  q_pop,
  output hem_in_t               q_data,
  // curve memory write port
  output logic                  wr_en,
  output logic [1:0]            wr_sel,
  output logic [LEVEL_BITS-1:0] wr_addr,
  output logic [RESP_W-1:0]     wr_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  hem_in_t            q_mem_r [QUEUE_DEPTH];
  logic [PW-1:0]      rd_ptr_r, wr_ptr_r;
  logic [PW:0]        cnt_r, cnt_nxt;
  logic               acc_load, acc_samp, idx_ok;

  // a load waits until every queued sample has read the curves
  assign in_ready = (cnt_r != (PW+1)'(QUEUE_DEPTH)) &&
                    ((in_data.req_type == REQ_SAMPLE) || (cnt_r == '0));
  assign acc_load = in_valid && in_ready && (in_data.req_type == REQ_LOAD);
  assign acc_samp = in_valid && in_ready && (in_data.req_type == REQ_SAMPLE);
  generate
    if (LEVEL_BITS < 16) begin : g_chk
      assign idx_ok = (in_data.table_index[15:LEVEL_BITS] == '0);
    end else begin : g_full
      assign idx_ok = 1'b1;
    end
  endgenerate

  assign wr_en   = acc_load && idx_ok;
  assign wr_sel  = in_data.table_select;
  assign wr_addr = in_data.table_index[LEVEL_BITS-1:0];
  assign wr_data = (in_data.table_select == SEL_WEIGHT) ?
                   {8'd0, in_data.table_value[15:0]} : in_data.table_value;

  assign q_valid = (cnt_r != '0);
  assign q_data  = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r + (PW+1)'(acc_samp) - (PW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (acc_samp) q_mem_r[wr_ptr_r] <= in_data;
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc_samp) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (q_pop)    rd_ptr_r <= rd_ptr_r + PW'(1);
    end
  end

endmodule

### rtl/hem_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hem_divider
// restoring divider, one quotient bit per cycle, floor(num*2^16/den) sat 24b
// ----------------------------------------------------------------------------
module hem_divider import hem_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] num,
  input  logic [ACC_W-1:0] den,
  output logic             done,
  output logic [RAD_W-1:0] quo
);

  localparam int QB = ACC_W + FRAC_BITS;   // 80 quotient bits in total
  localparam int CW = $clog2(QB + 1);

  logic [ACC_W:0]   rem_r, rem_nxt, trial;
  logic [QB-1:0]    dvd_r, dvd_nxt;
  logic [QB-1:0]    q_r, q_nxt;
  logic [ACC_W-1:0] den_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, zero_r;

  always_comb begin
    trial    = {rem_r[ACC_W-1:0], dvd_r[QB-1]};
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      dvd_nxt = {dvd_r[QB-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[QB-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[QB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      dvd_r  <= {num, {FRAC_BITS{1'b0}}};
      q_r    <= '0;
      den_r  <= den;
      zero_r <= (den == '0);
    end else begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
      q_r   <= q_nxt;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(QB);
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign done = !busy_r;
  assign quo  = zero_r ? '0 :
                (q_r[QB-1:RAD_W] != '0) ? {RAD_W{1'b1}} : q_r[RAD_W-1:0];

endmodule

### rtl/hem_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hem_back
// curve lookup, products, saturating accumulation and the per-pixel divide
// ----------------------------------------------------------------------------
module hem_back import hem_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  hem_in_t               q_data,
  input  logic                  wr_en,
  input  logic [1:0]            wr_sel,
  input  logic [LEVEL_BITS-1:0] wr_addr,
  input  logic [RESP_W-1:0]     wr_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hem_out_t              out_data
);

  localparam int DEPTH = 1 << LEVEL_BITS;

  logic [RESP_W-1:0]   red_mem   [DEPTH];
  logic [RESP_W-1:0]   green_mem [DEPTH];
  logic [RESP_W-1:0]   blue_mem  [DEPTH];
  logic [WEIGHT_W-1:0] wgt_mem   [3][DEPTH];

  logic [LEVEL_BITS-1:0] lvl [3];
  logic [RESP_W-1:0]     resp_r [3];
  logic [WEIGHT_W-1:0]   w_r [3];
  logic [39:0]           rw_r [3], ws_r [3];
  logic [ACC_W-1:0]      pn_r [3], pd_r [3];
  logic [ACC_W-1:0]      num_r [3], den_r [3];
  logic [ACC_W:0]        sn [3], sd [3];
  logic [SCALE_W-1:0]    scale_r;
  logic                  last_r;
  logic [1:0]            ch_r, ch_nxt;
  hem_state_t            st_r, st_nxt;
  logic                  div_start, div_done;
  logic [RAD_W-1:0]      div_q;
  logic [RAD_W-1:0]      rad_r [3];
  logic                  out_valid_r;

  assign lvl[0] = q_data.red_sample[15 -: LEVEL_BITS];
  assign lvl[1] = q_data.green_sample[15 -: LEVEL_BITS];
  assign lvl[2] = q_data.blue_sample[15 -: LEVEL_BITS];

  // curve memories, one copy of the weight curve per read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (wr_sel)
        SEL_RED:   red_mem[wr_addr]   <= wr_data;
        SEL_GREEN: green_mem[wr_addr] <= wr_data;
        SEL_BLUE:  blue_mem[wr_addr]  <= wr_data;
        SEL_WEIGHT: begin
          wgt_mem[0][wr_addr] <= wr_data[WEIGHT_W-1:0];
          wgt_mem[1][wr_addr] <= wr_data[WEIGHT_W-1:0];
          wgt_mem[2][wr_addr] <= wr_data[WEIGHT_W-1:0];
        end
        default: ;
      endcase
    end
    resp_r[0] <= red_mem[lvl[0]];
    resp_r[1] <= green_mem[lvl[1]];
    resp_r[2] <= blue_mem[lvl[2]];
    w_r[0]    <= wgt_mem[0][lvl[0]];
    w_r[1]    <= wgt_mem[1][lvl[1]];
    w_r[2]    <= wgt_mem[2][lvl[2]];
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sn[c] = {1'b0, num_r[c]} + {1'b0, pn_r[c]};
      sd[c] = {1'b0, den_r[c]} + {1'b0, pd_r[c]};
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    ch_nxt = ch_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_READ;
      ST_READ: st_nxt = ST_MUL1;
      ST_MUL1: st_nxt = ST_MUL2;
      ST_MUL2: st_nxt = ST_ACC;
      ST_ACC:  begin
        st_nxt = last_r ? ST_DIV : ST_IDLE;
        ch_nxt = 2'd0;
      end
      ST_DIV:  if (div_done && !div_start) begin
        if (ch_r == 2'd2) st_nxt = ST_OUT;
        else ch_nxt = ch_r + 2'd1;
      end
      ST_OUT:  if (!out_valid_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop = (st_r == ST_READ);
  end

  logic div_pend_r;
  assign div_start = (st_r == ST_DIV) && div_pend_r;

  hem_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r[ch_r]),
    .den   (den_r[ch_r]),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (st_r == ST_READ) begin
      scale_r <= q_data.exposure_scale;
      last_r  <= q_data.last_exposure;
    end
    for (int c = 0; c < 3; c++) begin
      rw_r[c] <= resp_r[c] * w_r[c];
      ws_r[c] <= 40'(w_r[c] * scale_r);
      pn_r[c] <= rw_r[c] * scale_r;
      pd_r[c] <= ws_r[c] * scale_r;
    end
    if ((st_r == ST_DIV) && div_done && !div_start) rad_r[ch_r] <= div_q;
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      div_pend_r  <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        num_r[c] <= '0;
        den_r[c] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      ch_r <= ch_nxt;
      if (st_r == ST_ACC) begin
        div_pend_r <= 1'b1;
        for (int c = 0; c < 3; c++) begin
          num_r[c] <= sn[c][ACC_W] ? {ACC_W{1'b1}} : sn[c][ACC_W-1:0];
          den_r[c] <= sd[c][ACC_W] ? {ACC_W{1'b1}} : sd[c][ACC_W-1:0];
        end
      end else if (div_start) begin
        div_pend_r <= 1'b0;
      end else if ((st_r == ST_DIV) && div_done) begin
        div_pend_r <= (ch_r != 2'd2);
      end
      if (st_r == ST_DIV && st_nxt == ST_OUT) begin
        out_valid_r <= 1'b1;
        for (int c = 0; c < 3; c++) begin
          num_r[c] <= '0;
          den_r[c] <= '0;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = '{red_radiance: rad_r[0], green_radiance: rad_r[1],
                       blue_radiance: rad_r[2]};

endmodule

### rtl/hdr_exposure_merge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_exposure_merge_unit
// weighted merge of bracketed exposures into one q8.16 rgb radiance pixel
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | hem_in_t  (sample or table load)
//  out     | out_valid / out_ready| hem_out_t (one pixel per last exposure)
//
//  table loads are accepted only once the sample queue is empty, so every earlier
//  sample has read the curves before the entry changes
//  a sample passes the back-end states idle, read, two multiply stages and add
//  a last exposure then has one shared bit-serial divider run the three
//  channels in turn
//  the two-entry sample queue lets the front keep taking samples while the back
//  works; rst_n is synchronous and clears control and the accumulators only
// ----------------------------------------------------------------------------
module hdr_exposure_merge_unit import hem_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hem_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hem_out_t out_data
);

  logic                  q_valid, q_pop;
  hem_in_t               q_data;
  logic                  wr_en;
  logic [1:0]            wr_sel;
  logic [LEVEL_BITS-1:0] wr_addr;
  logic [RESP_W-1:0]     wr_data;

  // front: classify, load tables, queue samples
  hem_front #(.LEVEL_BITS(LEVEL_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_pop, .q_data, .wr_en, .wr_sel, .wr_addr, .wr_data
  );

  // back: lookup, accumulate, divide, deliver
  hem_back #(.LEVEL_BITS(LEVEL_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data, .wr_en, .wr_sel, .wr_addr,
    .wr_data, .out_valid, .out_ready, .out_data
  );

  // never pop an empty queue
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty sample queue");

  // a waiting pixel holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // table writes come only from accepted load items
  a_load_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> in_valid && in_ready && in_data.req_type == REQ_LOAD)
    else $error("table write without a load item");

endmodule
